### hdl/tgkl_pkg.sv
// Shared types and constants of the touch grid key latch.
package tgkl_pkg;

    // Coordinate width of a cell edge: origin plus up to eight 15-bit cell sizes, signed.
    localparam int COORD_W = 20;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_W    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_H    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_MODE = 3'd4;

    localparam logic [14:0] CELL_SIZE_RESET = 15'd50;

    // Grid placement and mode.
    typedef struct packed {
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
        logic        [14:0] cell_w;
        logic        [14:0] cell_h;
        logic               hold_mode;
    } t_cfg;

endpackage

### hdl/tgkl_hit_test.sv
// Hit test of one touch point against the grid of equal cells.
module tgkl_hit_test #(
    parameter int ROWS = 4,
    parameter int COLS = 4,
    parameter int RW   = 2,
    parameter int CW   = 2
) (
    input  tgkl_pkg::t_cfg     i_cfg,
    input  logic signed [15:0] i_x,
    input  logic signed [15:0] i_y,
    output logic               o_hit,
    output logic [RW-1:0]      o_row,
    output logic [CW-1:0]      o_col
);

    logic signed [tgkl_pkg::COORD_W-1:0] x_e;
    logic signed [tgkl_pkg::COORD_W-1:0] y_e;
    logic signed [tgkl_pkg::COORD_W-1:0] ox_e;
    logic signed [tgkl_pkg::COORD_W-1:0] oy_e;
    logic signed [tgkl_pkg::COORD_W-1:0] w_e;
    logic signed [tgkl_pkg::COORD_W-1:0] h_e;
    logic [COLS-1:0] col_in;
    logic [ROWS-1:0] row_in;
    logic [RW-1:0]   first_row;
    logic [CW-1:0]   first_col;

    assign x_e  = tgkl_pkg::COORD_W'(i_x);
    assign y_e  = tgkl_pkg::COORD_W'(i_y);
    assign ox_e = tgkl_pkg::COORD_W'(i_cfg.origin_x);
    assign oy_e = tgkl_pkg::COORD_W'(i_cfg.origin_y);
    assign w_e  = signed'(tgkl_pkg::COORD_W'(i_cfg.cell_w));
    assign h_e  = signed'(tgkl_pkg::COORD_W'(i_cfg.cell_h));

    // Row and column bands test independently; a cell hits when both do.
    for (genvar c = 0; c < COLS; c++) begin : g_col
        logic signed [tgkl_pkg::COORD_W-1:0] lo;
        logic signed [tgkl_pkg::COORD_W-1:0] hi;
        assign lo = ox_e + signed'(tgkl_pkg::COORD_W'(c)) * w_e;
        assign hi = lo + w_e;
        assign col_in[c] = (x_e >= lo) && (x_e < hi);
    end

    for (genvar r = 0; r < ROWS; r++) begin : g_row
        logic signed [tgkl_pkg::COORD_W-1:0] lo;
        logic signed [tgkl_pkg::COORD_W-1:0] hi;
        assign lo = oy_e + signed'(tgkl_pkg::COORD_W'(r)) * h_e;
        assign hi = lo + h_e;
        assign row_in[r] = (y_e >= lo) && (y_e < hi);
    end

    // Lowest index wins, matching a row-major scan.
    always_comb begin
        first_row = '0;
        for (int r = ROWS - 1; r >= 0; r--) begin
            if (row_in[r]) begin
                first_row = RW'(r);
            end
        end
    end

    always_comb begin
        first_col = '0;
        for (int c = COLS - 1; c >= 0; c--) begin
            if (col_in[c]) begin
                first_col = CW'(c);
            end
        end
    end

    assign o_hit = (|row_in) && (|col_in);
    assign o_row = o_hit ? first_row : '0;
    assign o_col = o_hit ? first_col : '0;

endmodule

### hdl/touch_grid_key_latch.sv
// Top level of the touch grid key latch: item registers, cell state and result register.
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+------------------------------------------
//  in       | to block  | i_in_valid / o_in_stall    | i_touch_x, i_touch_y, i_pressed
//  out      | from block| o_out_valid / i_out_stall  | o_hit, o_hit_row, o_hit_col,
//           |           |                            | o_active_bits, o_touched_bits, o_changed_bits
//  cfg      | to block  | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One item per cycle sustained while the result side does not stall; an item passes from the
// input register to the result register, with the hit test and state update run between them.
// The hit test is one bank of parallel edge compares feeding small row and column priority encoders.
// Synchronous reset clears valids, cell state, held cell, origin and mode; cell sizes go to 50.
// A stalled result holds in the output register; the input register still takes one
// more item, then o_in_stall rises until the result moves on.
// o_cfg_ready is always high; writes to indexes beyond the register list are dropped.
module touch_grid_key_latch #(
    parameter int ROWS = 4,
    parameter int COLS = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // touch items
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic signed [15:0]                 i_touch_x,
    input  logic signed [15:0]                 i_touch_y,
    input  logic                               i_pressed,
    // results
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_hit,
    output logic [1:0]                         o_hit_row,
    output logic [1:0]                         o_hit_col,
    output logic [15:0]                        o_active_bits,
    output logic [15:0]                        o_touched_bits,
    output logic [15:0]                        o_changed_bits,
    // configuration writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tgkl_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [15:0]                        i_cfg_data
);

    localparam int NC = ROWS * COLS;
    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int IW = (NC > 1) ? $clog2(NC) : 1;

    // Configuration.
    tgkl_pkg::t_cfg r_cfg;

    // Input register.
    logic               r_in_valid;
    logic signed [15:0] r_x;
    logic signed [15:0] r_y;
    logic               r_press;

    // Cell state.
    logic [NC-1:0] r_active;
    logic [NC-1:0] r_touched;
    logic          r_holding;
    logic [RW-1:0] r_held_row;
    logic [CW-1:0] r_held_col;

    // Result register.
    logic          r_out_valid;
    logic          r_hit;
    logic [1:0]    r_row;
    logic [1:0]    r_col;
    logic [15:0]   r_active_out;
    logic [15:0]   r_touched_out;
    logic [15:0]   r_changed_out;

    // Next values.
    logic [NC-1:0] n_active;
    logic [NC-1:0] n_touched;
    logic [NC-1:0] n_changed;
    logic          n_holding;
    logic [RW-1:0] n_held_row;
    logic [CW-1:0] n_held_col;

    logic          hit;
    logic [RW-1:0] hit_row;
    logic [CW-1:0] hit_col;
    logic [IW-1:0] hit_idx;
    logic [IW-1:0] held_idx;
    logic [NC-1:0] hit_mask;
    logic [NC-1:0] held_mask;
    logic          same_cell;

    logic out_ready;
    logic advance;
    logic in_take;

    // Handshake: the result register frees when empty or taken; the input
    // register moves into it then.
    assign out_ready  = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_ready;
    assign o_in_stall = r_in_valid && !out_ready;
    assign in_take    = i_in_valid && !o_in_stall;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x  <= '0;
            r_cfg.origin_y  <= '0;
            r_cfg.cell_w    <= tgkl_pkg::CELL_SIZE_RESET;
            r_cfg.cell_h    <= tgkl_pkg::CELL_SIZE_RESET;
            r_cfg.hold_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tgkl_pkg::REG_ORIGIN_X:  r_cfg.origin_x  <= i_cfg_data;
                tgkl_pkg::REG_ORIGIN_Y:  r_cfg.origin_y  <= i_cfg_data;
                tgkl_pkg::REG_CELL_W:    r_cfg.cell_w    <= i_cfg_data[14:0];
                tgkl_pkg::REG_CELL_H:    r_cfg.cell_h    <= i_cfg_data[14:0];
                tgkl_pkg::REG_HOLD_MODE: r_cfg.hold_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Capture the touch item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_x     <= i_touch_x;
            r_y     <= i_touch_y;
            r_press <= i_pressed;
        end
    end

    tgkl_hit_test #(
        .ROWS (ROWS),
        .COLS (COLS),
        .RW   (RW),
        .CW   (CW)
    ) u_hit_test (
        .i_cfg (r_cfg),
        .i_x   (r_x),
        .i_y   (r_y),
        .o_hit (hit),
        .o_row (hit_row),
        .o_col (hit_col)
    );

    // Cell bit positions, row-major.
    assign hit_idx   = IW'(hit_row) * IW'(COLS) + IW'(hit_col);
    assign held_idx  = IW'(r_held_row) * IW'(COLS) + IW'(r_held_col);
    assign hit_mask  = NC'(1) << hit_idx;
    assign held_mask = NC'(1) << held_idx;
    assign same_cell = r_holding && (r_held_row == hit_row) && (r_held_col == hit_col);

    always_comb begin
        n_active   = r_active;
        n_touched  = r_touched;
        n_changed  = '0;
        n_holding  = r_holding;
        n_held_row = r_held_row;
        n_held_col = r_held_col;
        if (hit) begin
            if (r_press) begin
                n_touched = n_touched | hit_mask;
                // A press on the cell already held only marks it touched.
                if (!same_cell) begin
                    if (!r_cfg.hold_mode) begin
                        n_active  = n_active ^ hit_mask;
                        n_changed = hit_mask;
                    end else begin
                        // Slide: drop the old cell, then take the new one.
                        if (r_holding) begin
                            n_active  = n_active & ~held_mask;
                            n_changed = held_mask;
                        end
                        n_active  = n_active | hit_mask;
                        n_changed = n_changed | hit_mask;
                    end
                end
                n_holding  = 1'b1;
                n_held_row = hit_row;
                n_held_col = hit_col;
            end else begin
                // Release inside the grid acts on the hit cell.
                n_touched = n_touched & ~hit_mask;
                if (r_cfg.hold_mode) begin
                    n_active  = n_active & ~hit_mask;
                    n_changed = hit_mask;
                end
                n_holding  = 1'b0;
                n_held_row = '0;
                n_held_col = '0;
            end
        end else if (r_holding && r_press) begin
            // Slid off the grid: let go of the held cell.
            if (r_cfg.hold_mode) begin
                n_active  = n_active & ~held_mask;
                n_changed = held_mask;
            end
            n_holding  = 1'b0;
            n_held_row = '0;
            n_held_col = '0;
        end
    end

    // Advance the cell state with each item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= '0;
            r_touched  <= '0;
            r_holding  <= 1'b0;
            r_held_row <= '0;
            r_held_col <= '0;
        end else if (advance) begin
            r_active   <= n_active;
            r_touched  <= n_touched;
            r_holding  <= n_holding;
            r_held_row <= n_held_row;
            r_held_col <= n_held_col;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_hit         <= hit;
            r_row         <= 2'(hit_row);
            r_col         <= 2'(hit_col);
            r_active_out  <= 16'({16'b0, n_active});
            r_touched_out <= 16'({16'b0, n_touched});
            r_changed_out <= 16'({16'b0, n_changed});
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_hit          = r_hit;
    assign o_hit_row      = r_row;
    assign o_hit_col      = r_col;
    assign o_active_bits  = r_active_out;
    assign o_touched_bits = r_touched_out;
    assign o_changed_bits = r_changed_out;

endmodule

### hdl/tgkl_checker.sv
// Port-level checks of the touch grid key latch and their binding to the top level.
module tgkl_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic                           o_hit,
    input logic [1:0]                     o_hit_row,
    input logic [1:0]                     o_hit_col,
    input logic [15:0]                    o_active_bits,
    input logic [15:0]                    o_touched_bits,
    input logic [15:0]                    o_changed_bits
);

    // A stalled result stays valid and keeps its hit flag and bit vectors.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_hit)
            && $stable(o_active_bits) && $stable(o_touched_bits)
            && $stable(o_changed_bits))
        else $error("result changed while stalled");

    // A miss reports cell zero.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_hit |-> o_hit_row == 2'd0 && o_hit_col == 2'd0)
        else $error("miss with nonzero cell");

    // One event redraws at most the old and the new cell.
    a_changed_few: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $countones(o_changed_bits) <= 2)
        else $error("too many changed cells");

    // The input backs up only behind a stalled result.
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled while the result side is free");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind touch_grid_key_latch tgkl_checker u_tgkl_checker (.*);

### tb/sv/touch_grid_key_latch_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the touch grid key latch: directed and random touch items.
module touch_grid_key_latch_tb;

    localparam int KEY_ROWS      = 4;
    localparam int KEY_COLS      = 4;
    localparam int IDX_W         = tgkl_pkg::CFG_IDX_W;
    localparam int LONG_HOLD     = 80;   // receiver hold-off that backs the block up
    localparam int SETTLE_CYCLES = 8;    // idle time after the bench drains
    localparam logic MODE_TOGGLE = 1'b0;
    localparam logic MODE_HOLD   = 1'b1;
    localparam logic [IDX_W-1:0] REG_LAST_SPARE = '1;

    // One touch item as offered on the input channel.
    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               pressed;
    } t_touch;

    // Grid view that one touch item produces.
    typedef struct {
        logic        hit;
        logic [1:0]  row;
        logic [1:0]  col;
        logic [15:0] active;
        logic [15:0] touched;
        logic [15:0] changed;
    } t_key_view;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_in_valid     = 1'b0;
    logic                 o_in_stall;
    logic signed [15:0]   i_touch_x      = '0;
    logic signed [15:0]   i_touch_y      = '0;
    logic                 i_pressed      = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall    = 1'b0;
    logic                 o_hit;
    logic [1:0]           o_hit_row;
    logic [1:0]           o_hit_col;
    logic [15:0]          o_active_bits;
    logic [15:0]          o_touched_bits;
    logic [15:0]          o_changed_bits;
    logic                 i_cfg_valid    = 1'b0;
    logic                 o_cfg_ready;
    logic [IDX_W-1:0]     i_cfg_index    = '0;
    logic [15:0]          i_cfg_data     = '0;

    touch_grid_key_latch #(
        .ROWS(KEY_ROWS),
        .COLS(KEY_COLS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_touch_x     (i_touch_x),
        .i_touch_y     (i_touch_y),
        .i_pressed     (i_pressed),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_hit         (o_hit),
        .o_hit_row     (o_hit_row),
        .o_hit_col     (o_hit_col),
        .o_active_bits (o_active_bits),
        .o_touched_bits(o_touched_bits),
        .o_changed_bits(o_changed_bits),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // 2 ns period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow of the grid: placement, mode and key state, at reset values.
    // Coordinates are kept as longint so edge sums never wrap.
    // ------------------------------------------------------------------
    longint      grid_x0      = 0;
    longint      grid_y0      = 0;
    longint      pitch_x      = 50;
    longint      pitch_y      = 50;
    logic        latch_mode   = MODE_TOGGLE;
    logic [15:0] keys_active  = '0;
    logic [15:0] keys_touched = '0;
    logic        finger_down  = 1'b0;
    logic [1:0]  held_r       = '0;
    logic [1:0]  held_c       = '0;

    t_touch    touch_backlog[$];   // items waiting to be offered
    t_key_view latched_views[$];   // grid views owed by the block, oldest first
    t_touch    offered;            // item currently on the input port
    int        queued_count  = 0;
    int        send_gap      = 0;
    int        stall_left    = 0;
    int        hold_left     = 0;
    int        hold_requests = 0;
    int        hold_served   = 0;
    int        mismatches    = 0;
    bit        sender_idle   = 1'b1;
    bit        recv_idle     = 1'b1;

    function automatic logic [15:0] cell_mask(logic [1:0] r, logic [1:0] c);
        return 16'h1 << (int'(r) * KEY_COLS + int'(c));
    endfunction

    // Hit-test one touch, update the key state and return the view it yields.
    function automatic t_key_view latch_touch(t_touch ev);
        t_key_view   v;
        longint      px;
        longint      py;
        longint      left;
        longint      top;
        logic [15:0] b;
        logic [15:0] ob;
        v.hit     = 1'b0;
        v.row     = '0;
        v.col     = '0;
        v.changed = '0;
        px = longint'($signed(ev.x));
        py = longint'($signed(ev.y));
        // row-major scan, first matching cell wins
        for (int r = 0; r < KEY_ROWS; r++) begin
            for (int c = 0; c < KEY_COLS; c++) begin
                top  = grid_y0 + longint'(r) * pitch_y;
                left = grid_x0 + longint'(c) * pitch_x;
                if (!v.hit && px >= left && px < left + pitch_x
                        && py >= top && py < top + pitch_y) begin
                    v.hit = 1'b1;
                    v.row = 2'(r);
                    v.col = 2'(c);
                end
            end
        end
        b  = cell_mask(v.row, v.col);
        ob = cell_mask(held_r, held_c);
        if (v.hit && ev.pressed) begin
            keys_touched |= b;
            // pressing the cell already held changes nothing else
            if (!finger_down || held_r != v.row || held_c != v.col) begin
                if (latch_mode == MODE_TOGGLE) begin
                    keys_active ^= b;
                    v.changed   |= b;
                end else begin
                    if (finger_down) begin
                        keys_active &= ~ob;
                        v.changed   |= ob;
                    end
                    keys_active |= b;
                    v.changed   |= b;
                end
            end
            finger_down = 1'b1;
            held_r      = v.row;
            held_c      = v.col;
        end else if (v.hit) begin
            // release clears the cell under the finger, not the held one
            keys_touched &= ~b;
            if (latch_mode == MODE_HOLD) begin
                keys_active &= ~b;
                v.changed   |= b;
            end
            finger_down = 1'b0;
            held_r      = '0;
            held_c      = '0;
        end else if (finger_down && ev.pressed) begin
            // slid off the grid
            if (latch_mode == MODE_HOLD) begin
                keys_active &= ~ob;
                v.changed   |= ob;
            end
            finger_down = 1'b0;
            held_r      = '0;
            held_c      = '0;
        end
        v.active  = keys_active;
        v.touched = keys_touched;
        return v;
    endfunction

    function automatic void apply_reg(logic [IDX_W-1:0] idx, logic [15:0] data);
        case (idx)
            tgkl_pkg::REG_ORIGIN_X:  grid_x0    = longint'($signed(data));
            tgkl_pkg::REG_ORIGIN_Y:  grid_y0    = longint'($signed(data));
            tgkl_pkg::REG_CELL_W:    pitch_x    = longint'(data[14:0]);
            tgkl_pkg::REG_CELL_H:    pitch_y    = longint'(data[14:0]);
            tgkl_pkg::REG_HOLD_MODE: latch_mode = data[0];
            default: ;   // spare indexes are dropped by the block
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: offer items from the backlog, predict each one as it is taken.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                latched_views.push_back(latch_touch(offered));
            end
            // hold a stalled item; otherwise advance, idle or drop valid
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (touch_backlog.size() != 0 && sender_idle
                        && $urandom_range(0, 5) == 0) begin
                    send_gap = $urandom_range(1, 15) - 1;
                    i_in_valid <= 1'b0;
                end else if (touch_backlog.size() != 0) begin
                    offered = touch_backlog.pop_front();
                    i_touch_x  <= offered.x;
                    i_touch_y  <= offered.y;
                    i_pressed  <= offered.pressed;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic report_field(string name, logic [15:0] want_v, logic [15:0] got_v);
        mismatches++;
        $display("%0t: %s mismatch, expected 0x%04h, got 0x%04h", $time, name, want_v, got_v);
    endtask

    // ------------------------------------------------------------------
    // Monitor: check each taken result against the oldest prediction and
    // drive the result stall (random bursts plus the requested long hold).
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_key_view want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (latched_views.size() == 0) begin
                mismatches++;
                $display("%0t: result with no item outstanding, expected none, got hit=%0b",
                         $time, o_hit);
            end else begin
                want = latched_views.pop_front();
                if (o_hit !== want.hit)
                    report_field("hit", 16'(want.hit), 16'(o_hit));
                if (o_hit_row !== want.row)
                    report_field("hit_row", 16'(want.row), 16'(o_hit_row));
                if (o_hit_col !== want.col)
                    report_field("hit_col", 16'(want.col), 16'(o_hit_col));
                if (o_active_bits !== want.active)
                    report_field("active_bits", want.active, o_active_bits);
                if (o_touched_bits !== want.touched)
                    report_field("touched_bits", want.touched, o_touched_bits);
                if (o_changed_bits !== want.changed)
                    report_field("changed_bits", want.changed, o_changed_bits);
            end
        end
        if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left   = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (recv_idle && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 15) - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic bit fits16(longint v);
        return v >= -32768 && v <= 32767;
    endfunction

    function automatic void queue_touch(longint x, longint y, logic p);
        t_touch t;
        t.x       = 16'(x);
        t.y       = 16'(y);
        t.pressed = p;
        touch_backlog.push_back(t);
        queued_count++;
    endfunction

    // Point inside [base, base+size), edges weighted.
    function automatic longint pick_inside(longint base, longint size);
        if (size == 0)
            return base;
        case ($urandom_range(0, 5))
            0:       return base;
            1:       return base + size - 1;
            default: return base + longint'($urandom_range(0, int'(size) - 1));
        endcase
    endfunction

    function automatic void queue_on_cell(int r, int c, logic p);
        longint px;
        longint py;
        px = pick_inside(grid_x0 + longint'(c) * pitch_x, pitch_x);
        py = pick_inside(grid_y0 + longint'(r) * pitch_y, pitch_y);
        if (fits16(px) && fits16(py))
            queue_touch(px, py, p);
        else
            queue_touch($urandom, $urandom, p);
    endfunction

    // Point just past one of the grid edges, or anywhere.
    function automatic void queue_off_grid(logic p);
        longint px;
        longint py;
        px = pick_inside(grid_x0, longint'(KEY_COLS) * pitch_x);
        py = pick_inside(grid_y0, longint'(KEY_ROWS) * pitch_y);
        case ($urandom_range(0, 4))
            0:       px = grid_x0 - 1;
            1:       px = grid_x0 + longint'(KEY_COLS) * pitch_x;
            2:       py = grid_y0 - 1;
            3:       py = grid_y0 + longint'(KEY_ROWS) * pitch_y;
            default: begin
                px = longint'($signed(16'($urandom)));
                py = longint'($signed(16'($urandom)));
            end
        endcase
        if (fits16(px) && fits16(py))
            queue_touch(px, py, p);
        else
            queue_touch($urandom, $urandom, p);
    endfunction

    // Press, a few slides, release.
    function automatic void queue_gesture();
        int r;
        int c;
        r = $urandom_range(0, KEY_ROWS - 1);
        c = $urandom_range(0, KEY_COLS - 1);
        queue_on_cell(r, c, 1'b1);
        repeat ($urandom_range(0, 4)) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: queue_on_cell(r, c, 1'b1);
                8:          queue_off_grid(1'b1);
                9:          queue_touch($urandom, $urandom, 1'b1);
                default: begin
                    r = $urandom_range(0, KEY_ROWS - 1);
                    c = $urandom_range(0, KEY_COLS - 1);
                    queue_on_cell(r, c, 1'b1);
                end
            endcase
        end
        case ($urandom_range(0, 9))
            7, 8:    queue_on_cell($urandom_range(0, KEY_ROWS - 1),
                                   $urandom_range(0, KEY_COLS - 1), 1'b0);
            9:       queue_off_grid(1'b0);
            default: queue_on_cell(r, c, 1'b0);
        endcase
    endfunction

    function automatic void queue_random_touches(int n_items);
        int goal;
        goal = queued_count + n_items;
        while (queued_count < goal) begin
            if ($urandom_range(0, 6) == 0)
                queue_touch($urandom, $urandom, 1'($urandom));
            else
                queue_gesture();
        end
    endfunction

    // Called at a falling edge; returns at a falling edge.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (touch_backlog.size() != 0 || i_in_valid || latched_views.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [15:0] data);
        logic rdy;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do begin
            @(negedge i_clk);
            rdy = o_cfg_ready;
            @(posedge i_clk);
        end while (!rdy);
        apply_reg(idx, data);
    endtask

    // Rewrite every register; unused upper bits carry noise, and a spare
    // index is sometimes hit to show it is dropped.
    task automatic program_grid(int x0, int y0, int w, int h, logic hold);
        @(posedge i_clk);
        write_reg(tgkl_pkg::REG_ORIGIN_X, 16'(x0));
        write_reg(tgkl_pkg::REG_ORIGIN_Y, 16'(y0));
        write_reg(tgkl_pkg::REG_CELL_W, {1'($urandom), 15'(w)});
        write_reg(tgkl_pkg::REG_CELL_H, {1'($urandom), 15'(h)});
        write_reg(tgkl_pkg::REG_HOLD_MODE, {15'($urandom), hold});
        if ($urandom_range(0, 2) == 0)
            write_reg(IDX_W'($urandom_range(int'(tgkl_pkg::REG_HOLD_MODE) + 1,
                                             int'(REG_LAST_SPARE))), 16'($urandom));
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int x0;
        int y0;
        int w;
        int h;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset grid: 50x50 cells at the origin, toggle mode.
        queue_touch(0, 0, 1'b1);             // first press toggles on
        queue_touch(0, 0, 1'b1);             // press on the held cell
        queue_touch(199, 199, 1'b1);         // slide to the far corner cell
        queue_touch(199, 199, 1'b0);         // release inside
        queue_touch(500, 500, 1'b0);         // release outside
        queue_touch(-32768, -32768, 1'b1);   // press outside, not holding
        queue_touch(49, 50, 1'b1);
        queue_touch(32767, 32767, 1'b1);     // press outside while holding
        queue_touch(200, 0, 1'b1);           // right edge is exclusive
        queue_touch(199, 0, 1'b1);
        queue_touch(10, 10, 1'b0);           // release on a cell other than the held one
        wait_drained();

        // Extreme placement and size, hold mode.
        program_grid(32767, -32768, 32767, 32767, MODE_HOLD);
        queue_touch(32767, -32768, 1'b1);
        queue_touch(32767, 0, 1'b1);         // slide down one row
        queue_touch(32767, 32766, 1'b1);
        queue_touch(32767, -5, 1'b0);        // release on another cell
        queue_touch(32767, 100, 1'b1);
        queue_touch(0, 0, 1'b1);             // slide off the grid
        queue_touch(32767, 100, 1'b1);       // hold again, then switch modes
        wait_drained();
        program_grid(32767, -32768, 32767, 32767, MODE_TOGGLE);
        queue_touch(32767, 100, 1'b1);
        queue_touch(32767, -32768, 1'b1);
        wait_drained();

        // 1x1 cells in the opposite corner.
        program_grid(-32768, 32767, 1, 1, MODE_TOGGLE);
        queue_touch(-32765, 32767, 1'b1);
        queue_touch(-32764, 32767, 1'b1);
        queue_touch(-32768, 32767, 1'b0);
        wait_drained();

        // Zero-width and zero-height cells never hit.
        program_grid(0, 0, 0, 50, MODE_HOLD);
        queue_touch(0, 0, 1'b1);
        wait_drained();
        program_grid(0, 0, 50, 0, MODE_TOGGLE);
        queue_touch(10, 0, 1'b1);

        // Random phases, each with fresh placement and mode.
        for (int p = 0; p < 12; p++) begin
            wait_drained();
            x0 = ($urandom_range(0, 4) == 0) ? int'(16'($urandom))
                                             : int'($urandom_range(0, 600)) - 300;
            y0 = ($urandom_range(0, 4) == 0) ? int'(16'($urandom))
                                             : int'($urandom_range(0, 600)) - 300;
            case ($urandom_range(0, 7))
                0:       w = $urandom_range(1, 32767);
                1:       w = 32767;
                2:       w = 1;
                default: w = $urandom_range(2, 80);
            endcase
            case ($urandom_range(0, 7))
                0:       h = $urandom_range(1, 32767);
                1:       h = 32767;
                2:       h = 1;
                default: h = $urandom_range(2, 80);
            endcase
            program_grid(x0, y0, w, h, 1'($urandom));
            // no idling at all in the last phase, and now and then elsewhere
            sender_idle = (p != 11) && ($urandom_range(0, 3) != 0);
            recv_idle   = (p != 11) && ($urandom_range(0, 3) != 0);
            // hold the result side off for LONG_HOLD at the start of the third phase
            if (p == 2)
                hold_requests++;
            queue_random_touches(127);
        end
        wait_drained();

        if (mismatches == 0)
            $display("touch_grid_key_latch test passed");
        else
            $display("touch_grid_key_latch test failed");
        $finish;
    end

    // Watchdog: ends a run that hangs.
    initial begin
        #2000000;
        $display("touch_grid_key_latch test failed");
        $finish;
    end

endmodule

### filelist.f
hdl/tgkl_pkg.sv
hdl/tgkl_hit_test.sv
hdl/touch_grid_key_latch.sv
hdl/tgkl_checker.sv
tb/sv/touch_grid_key_latch_tb.sv
